// ===== sv/dtss_pkg.sv =====
// Types and constants shared by the distance sort and statistics block.
`timescale 1ns / 1ps

package dtss_pkg;

  localparam int MaxRecordsDefault = 32;
  localparam int TagW   = 8;
  localparam int DistW  = 16;
  localparam int SumW   = 21;
  localparam int RepW   = 6;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;

  localparam logic [DistW-1:0] FAR_LIMIT_RST  = 16'd200;
  localparam logic [DistW-1:0] NEAR_LIMIT_RST = 16'd80;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FAR_LIMIT  = 1'b0,
    REG_NEAR_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TagW-1:0]  record_tag;
    logic [DistW-1:0] distance;
    logic             final_record;
  } in_item_t;

  typedef struct packed {
    logic [TagW-1:0]  sorted_tag;
    logic [DistW-1:0] sorted_distance;
    logic             end_of_run;
    logic [SumW-1:0]  distance_total;
    logic [RepW-1:0]  record_count;
    logic [TagW-1:0]  farthest_tag;
    logic [TagW-1:0]  nearest_tag;
    logic [RepW-1:0]  far_total;
    logic [RepW-1:0]  near_total;
    logic             overflowed;
  } out_item_t;

  // One record held by a cell of the sorting row.
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [DistW-1:0] distance;
  } rec_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  // Statistics reported with every result.
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [TagW-1:0] far_tag;
    logic [TagW-1:0] near_tag;
    logic [RepW-1:0] far_cnt;
    logic [RepW-1:0] near_cnt;
    logic            dropped;
  } stats_t;

endpackage

// ===== sv/dtss_cell.sv =====
// One cell of the insertion sorting row: holds a record, inserts or shifts.
`timescale 1ns / 1ps

module dtss_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic               clk,
  input  dtss_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   cnt,
  input  dtss_pkg::rec_t     new_rec,
  input  dtss_pkg::rec_t     left_rec,
  input  logic               left_keep,
  input  dtss_pkg::rec_t     right_rec,
  output dtss_pkg::rec_t     rec,
  output logic               keep
);
  import dtss_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;
  logic occ;

  assign occ  = cnt > CNT_W'(IDX);
  // Equal distances stay ahead of the newcomer, which keeps arrival order.
  assign keep = occ && (new_rec.distance >= rec_r.distance);
  assign rec  = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.insert) begin
      if (!keep) begin
        rec_nxt = left_keep ? new_rec : left_rec;
      end
    end else if (ctl.shift) begin
      rec_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

// ===== sv/dtss_stats.sv =====
// Running sum, first largest and smallest record and threshold counts of a set.
`timescale 1ns / 1ps

module dtss_stats #(
  parameter int CNT_W = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       upd,
  input  logic                       drop,
  input  logic                       clr,
  input  logic                       first,
  input  dtss_pkg::rec_t             rec,
  input  logic [dtss_pkg::DistW-1:0] far_limit,
  input  logic [dtss_pkg::DistW-1:0] near_limit,
  output dtss_pkg::stats_t           stats
);
  import dtss_pkg::*;

  logic [SumW-1:0]  sum_r, sum_nxt;
  logic [TagW-1:0]  far_tag_r, far_tag_nxt, near_tag_r, near_tag_nxt;
  logic [DistW-1:0] far_dist_r, far_dist_nxt, near_dist_r, near_dist_nxt;
  logic [CNT_W-1:0] far_cnt_r, far_cnt_nxt, near_cnt_r, near_cnt_nxt;
  logic             drop_r, drop_nxt;
  logic [SumW:0]    sum_wide;

  assign sum_wide = {1'b0, sum_r} + (SumW + 1)'(rec.distance);

  always_comb begin
    sum_nxt       = sum_r;
    far_tag_nxt   = far_tag_r;
    far_dist_nxt  = far_dist_r;
    near_tag_nxt  = near_tag_r;
    near_dist_nxt = near_dist_r;
    far_cnt_nxt   = far_cnt_r;
    near_cnt_nxt  = near_cnt_r;
    drop_nxt      = drop_r;
    if (clr) begin
      sum_nxt       = '0;
      far_tag_nxt   = '0;
      far_dist_nxt  = '0;
      near_tag_nxt  = '0;
      near_dist_nxt = '0;
      far_cnt_nxt   = '0;
      near_cnt_nxt  = '0;
      drop_nxt      = 1'b0;
    end else if (drop) begin
      drop_nxt = 1'b1;
    end else if (upd) begin
      // The sum saturates rather than wrapping.
      sum_nxt = sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];
      if (first || rec.distance > far_dist_r) begin
        far_tag_nxt  = rec.tag;
        far_dist_nxt = rec.distance;
      end
      if (first || rec.distance < near_dist_r) begin
        near_tag_nxt  = rec.tag;
        near_dist_nxt = rec.distance;
      end
      if (rec.distance > far_limit) begin
        far_cnt_nxt = far_cnt_r + CNT_W'(1);
      end
      if (rec.distance < near_limit) begin
        near_cnt_nxt = near_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      far_tag_r   <= '0;
      far_dist_r  <= '0;
      near_tag_r  <= '0;
      near_dist_r <= '0;
      far_cnt_r   <= '0;
      near_cnt_r  <= '0;
      drop_r      <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      far_tag_r   <= far_tag_nxt;
      far_dist_r  <= far_dist_nxt;
      near_tag_r  <= near_tag_nxt;
      near_dist_r <= near_dist_nxt;
      far_cnt_r   <= far_cnt_nxt;
      near_cnt_r  <= near_cnt_nxt;
      drop_r      <= drop_nxt;
    end
  end

  assign stats.sum      = sum_r;
  assign stats.far_tag  = far_tag_r;
  assign stats.near_tag = near_tag_r;
  assign stats.far_cnt  = RepW'(far_cnt_r);
  assign stats.near_cnt = RepW'(near_cnt_r);
  assign stats.dropped  = drop_r;

endmodule

// ===== sv/distance_table_stats_and_sort.sv =====
// Top level: loads a record set into a sorting row of cells, then emits it sorted.
//
//   Channel | Direction | Handshake         | Payload
//   in_     | input     | in_valid/in_stall | dtss_pkg::in_item_t
//   out_    | output    | out_valid/out_stall | dtss_pkg::out_item_t
//   cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
// Loading accepts one record per cycle: every cell compares the new distance at
// once and the row opens a gap by shifting one place right in that same cycle.
// The final record ends loading; the set of n records then leaves one per cycle
// from the head cell, in any cycle in which out_stall is low.
// Inputs are stalled while a set is being emitted. Reset is synchronous and
// clears the fill count, the statistics and the state; cell contents need none.
`timescale 1ns / 1ps

module distance_table_stats_and_sort #(
  parameter int MAX_RECORDS = dtss_pkg::MaxRecordsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dtss_pkg::in_item_t            in_payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dtss_pkg::out_item_t           out_payload,
  input  logic                          cfg_we,
  input  logic [dtss_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dtss_pkg::CfgDataW-1:0] cfg_wdata
);
  import dtss_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [DistW-1:0] far_limit_r, near_limit_r;

  logic      in_acc, out_acc, full, ins, last_out;
  rec_t      new_rec;
  cell_ctl_t ctl;
  stats_t    stats;

  rec_t cell_rec  [MAX_RECORDS];
  logic cell_keep [MAX_RECORDS];

  assign in_stall  = (state_r != ST_LOAD);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign full      = (cnt_r == CNT_W'(MAX_RECORDS));
  assign ins       = in_acc && !full;
  assign last_out  = (idx_r == cnt_r - CNT_W'(1));

  assign new_rec.tag      = in_payload.record_tag;
  assign new_rec.distance = in_payload.distance;
  assign ctl.insert       = ins;
  assign ctl.shift        = out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_limit_r  <= FAR_LIMIT_RST;
      near_limit_r <= NEAR_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FAR_LIMIT:  far_limit_r  <= cfg_wdata;
        REG_NEAR_LIMIT: near_limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_LOAD: begin
        if (ins) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (in_acc && in_payload.final_record) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last_out) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_keep;

    if (i == 0) begin : g_head
      assign left_rec  = new_rec;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_rec  = cell_rec[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign right_rec = cell_rec[i];
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    dtss_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cnt       (cnt_r),
      .new_rec   (new_rec),
      .left_rec  (left_rec),
      .left_keep (left_keep),
      .right_rec (right_rec),
      .rec       (cell_rec[i]),
      .keep      (cell_keep[i])
    );
  end

  dtss_stats #(
    .CNT_W (CNT_W)
  ) u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (ins),
    .drop       (in_acc && full),
    .clr        (out_acc && last_out),
    .first      (cnt_r == '0),
    .rec        (new_rec),
    .far_limit  (far_limit_r),
    .near_limit (near_limit_r),
    .stats      (stats)
  );

  assign out_payload.sorted_tag      = cell_rec[0].tag;
  assign out_payload.sorted_distance = cell_rec[0].distance;
  assign out_payload.end_of_run      = last_out;
  assign out_payload.distance_total  = stats.sum;
  assign out_payload.record_count    = RepW'(cnt_r);
  assign out_payload.farthest_tag    = stats.far_tag;
  assign out_payload.nearest_tag     = stats.near_tag;
  assign out_payload.far_total       = stats.far_cnt;
  assign out_payload.near_total      = stats.near_cnt;
  assign out_payload.overflowed      = stats.dropped;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RECORDS))
    else $error("fill count exceeds capacity");

  a_final_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_payload.final_record) |=> (out_valid && cnt_r != '0))
    else $error("final record did not start a non-empty emission");

  a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_payload.end_of_run) |=> (!out_valid && cnt_r == '0))
    else $error("set state not cleared after the last result");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_payload.end_of_run) |=>
      (out_valid && out_payload.sorted_distance >= $past(out_payload.sorted_distance)))
    else $error("results not in ascending distance order");

  a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("stored record not counted");

endmodule

// ===== test/sort_check_pkg.sv =====
// Scoreboard that predicts the sorted record stream and checks each result against it.
`timescale 1ns / 1ps

package sort_check_pkg;
  import dtss_pkg::*;

  localparam int Capacity = MaxRecordsDefault;
  localparam int unsigned SumMax = (1 << SumW) - 1;
  localparam int ReportLimit = 10;

  class sorted_run_scoreboard;
    logic [DistW-1:0] far_limit = FAR_LIMIT_RST;
    logic [DistW-1:0] near_limit = NEAR_LIMIT_RST;

    // Records of the set being loaded, in arrival order.
    rec_t        loaded[$];
    int unsigned dist_sum = 0;
    rec_t        farthest;
    rec_t        nearest;
    int          far_count = 0;
    int          near_count = 0;
    logic        dropped = 1'b0;

    out_item_t   expected_sorted[$];

    int failures = 0;
    int records_seen = 0;
    int sets_closed = 0;
    int overflow_sets = 0;
    int results_checked = 0;

    function void set_limits(logic [DistW-1:0] far_v, logic [DistW-1:0] near_v);
      far_limit = far_v;
      near_limit = near_v;
    endfunction

    function int pending();
      return expected_sorted.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= ReportLimit) $display("error: %s", msg);
    endfunction

    // Takes one accepted transaction and, on the last record of a set, queues
    // the whole sorted run that the block owes.
    function void note_record(in_item_t rec);
      rec_t      incoming;
      rec_t      ordered[$];
      out_item_t res;
      int        pos;
      records_seen++;
      incoming.tag = rec.record_tag;
      incoming.distance = rec.distance;
      if (loaded.size() >= Capacity) begin
        dropped = 1'b1;
      end else begin
        if (loaded.size() == 0) begin
          farthest = incoming;
          nearest = incoming;
        end else begin
          if (incoming.distance > farthest.distance) farthest = incoming;
          if (incoming.distance < nearest.distance) nearest = incoming;
        end
        dist_sum += incoming.distance;
        if (dist_sum > SumMax) dist_sum = SumMax;
        if (incoming.distance > far_limit) far_count++;
        if (incoming.distance < near_limit) near_count++;
        loaded.push_back(incoming);
      end
      if (!rec.final_record) return;

      // Stable insertion: a record lands after every earlier one of equal distance.
      foreach (loaded[i]) begin
        pos = ordered.size();
        while (pos > 0 && ordered[pos-1].distance > loaded[i].distance) pos--;
        ordered.insert(pos, loaded[i]);
      end
      foreach (ordered[i]) begin
        res.sorted_tag = ordered[i].tag;
        res.sorted_distance = ordered[i].distance;
        res.end_of_run = (i == ordered.size() - 1);
        res.distance_total = SumW'(dist_sum);
        res.record_count = RepW'(ordered.size());
        res.farthest_tag = farthest.tag;
        res.nearest_tag = nearest.tag;
        res.far_total = RepW'(far_count);
        res.near_total = RepW'(near_count);
        res.overflowed = dropped;
        expected_sorted.push_back(res);
      end
      sets_closed++;
      if (dropped) overflow_sets++;

      loaded.delete();
      dist_sum = 0;
      farthest = '0;
      nearest = '0;
      far_count = 0;
      near_count = 0;
      dropped = 1'b0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      string     diffs;
      results_checked++;
      if (expected_sorted.size() == 0) begin
        report($sformatf("result %p arrived with no sorted record pending", got));
        return;
      end
      want = expected_sorted.pop_front();
      diffs = "";
      if (got.sorted_tag !== want.sorted_tag) diffs = {diffs, " sorted_tag"};
      if (got.sorted_distance !== want.sorted_distance) diffs = {diffs, " sorted_distance"};
      if (got.end_of_run !== want.end_of_run) diffs = {diffs, " end_of_run"};
      if (got.distance_total !== want.distance_total) diffs = {diffs, " distance_total"};
      if (got.record_count !== want.record_count) diffs = {diffs, " record_count"};
      if (got.farthest_tag !== want.farthest_tag) diffs = {diffs, " farthest_tag"};
      if (got.nearest_tag !== want.nearest_tag) diffs = {diffs, " nearest_tag"};
      if (got.far_total !== want.far_total) diffs = {diffs, " far_total"};
      if (got.near_total !== want.near_total) diffs = {diffs, " near_total"};
      if (got.overflowed !== want.overflowed) diffs = {diffs, " overflowed"};
      if (diffs != "")
        report($sformatf("result %0d differs in%s: expected %p, got %p",
                         results_checked, diffs, want, got));
    endfunction
  endclass

endpackage

// ===== test/tb.sv =====
// Self-checking testbench for the distance sort and statistics block.
`timescale 1ns / 1ps

module tb;
  import dtss_pkg::*;
  import sort_check_pkg::*;

  localparam int HoldCycles = 400;
  localparam int QuietLimit = 3000;
  localparam int SettleCycles = 8;
  localparam int PhaseRecords = 150;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_payload = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_payload;
  logic                cfg_we = 1'b0;
  cfg_reg_t            cfg_index = REG_FAR_LIMIT;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  sorted_run_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;
  int settings_tried = 0;

  distance_table_stats_and_sort uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_payload);
  end

  // Receiver stall, with one long hold-off on request so the block backs up.
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_record(input logic [TagW-1:0] tag, input logic [DistW-1:0] distance,
                             input bit last);
    in_item_t item;
    item.record_tag = tag;
    item.distance = distance;
    item.final_record = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_record(item);
  endtask

  // Stop sending and let every owed result drain before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_limits(input logic [DistW-1:0] far_v, input logic [DistW-1:0] near_v);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_FAR_LIMIT;
    cfg_wdata <= far_v;
    @(posedge clk);
    cfg_index <= REG_NEAR_LIMIT;
    cfg_wdata <= near_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limits(far_v, near_v);
    settings_tried++;
  endtask

  function automatic logic [DistW-1:0] pick_limit();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2, 3: return DistW'($urandom_range(65535));
      default: return DistW'($urandom_range(300));
    endcase
  endfunction

  task automatic run_directed();
    // Field extremes, each as a one-record set.
    send_record(8'hFF, 16'hFFFF, 1'b1);
    send_record(8'h00, 16'h0000, 1'b1);
    // Ties: the first largest and first smallest win, equal distances keep order.
    send_record(8'd1, 16'd500, 1'b0);
    send_record(8'd2, 16'd500, 1'b0);
    send_record(8'd3, 16'd10, 1'b0);
    send_record(8'd4, 16'd10, 1'b0);
    send_record(8'd5, 16'd500, 1'b0);
    send_record(8'd6, 16'd10, 1'b1);
    // Distances on both sides of the reset thresholds.
    send_record(8'd7, 16'd200, 1'b0);
    send_record(8'd8, 16'd201, 1'b0);
    send_record(8'd9, 16'd199, 1'b0);
    send_record(8'd10, 16'd80, 1'b0);
    send_record(8'd11, 16'd79, 1'b0);
    send_record(8'd12, 16'd81, 1'b1);
    write_limits(16'h0000, 16'hFFFF);
    send_record(8'd13, 16'h0000, 1'b0);
    send_record(8'd14, 16'hFFFF, 1'b0);
    send_record(8'd15, 16'h0001, 1'b0);
    send_record(8'd16, 16'hFFFE, 1'b1);
    write_limits(16'hFFFF, 16'h0000);
    send_record(8'd17, 16'hFFFF, 1'b0);
    send_record(8'd18, 16'h0000, 1'b0);
    send_record(8'd19, 16'h8000, 1'b1);
  endtask

  // Random sets: mostly short, some exactly full, some past capacity.
  task automatic run_random(input int quota);
    int               sent;
    int               size;
    int               kind;
    int               mode;
    logic [DistW-1:0] d;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(4) == 0) write_limits(pick_limit(), pick_limit());
      kind = $urandom_range(11);
      if (kind == 0) size = Capacity;
      else if (kind == 1) size = $urandom_range(Capacity + 4, Capacity + 1);
      else size = $urandom_range(8, 1);
      mode = $urandom_range(2);
      for (int i = 0; i < size; i++) begin
        case (mode)
          0: d = DistW'($urandom_range(65535));
          1: d = DistW'($urandom_range(15));
          default: d = ($urandom_range(1) ? sb.far_limit : sb.near_limit)
                       + DistW'($urandom_range(4)) - DistW'(2);
        endcase
        send_record(TagW'($urandom_range(255)), d, i == size - 1);
      end
      sent += size;
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 85;
    run_directed();
    run_random(PhaseRecords);

    send_idle_pct = 85;
    recv_idle_pct = 28;
    run_random(PhaseRecords);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_random(PhaseRecords);

    settle();
    $display("Sent %0d records in %0d sets (%0d past capacity); checked %0d sorted results.",
             sb.records_seen, sb.sets_closed, sb.overflow_sets, sb.results_checked);
    $display("Threshold registers took %0d settings across three stall mixes and a long hold.",
             settings_tried);
    if (sb.failures == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
